### rtl/clook_request_scheduler_core_defines.svh
// Assertion macros shared by the C-LOOK scheduler checker.
// No dependencies; expects clk and rst_n to be visible where used.
`ifndef CLOOK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define CLOOK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

// Checked at every rising edge while reset is released.
`define CLOOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CLOOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/clook_pkg.sv
// Shared types and constants of the C-LOOK request scheduler.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package clook_pkg;

  localparam int SECTOR_W  = 32;
  localparam int TAG_IN_W  = 8;
  localparam int TAG_MAX_W = 16;
  localparam int OCC_W     = 5;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } clook_op_t;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } clook_status_t;

  typedef struct packed {
    clook_op_t             operation;
    logic [SECTOR_W-1:0]   sector;
    logic                  is_write;
    logic [TAG_IN_W-1:0]   tag;
  } clook_in_t;

  typedef struct packed {
    clook_status_t         status;
    logic [SECTOR_W-1:0]   out_sector;
    logic                  out_is_write;
    logic [TAG_IN_W-1:0]   out_tag;
    logic [OCC_W-1:0]      occupancy;
  } clook_out_t;

  // Per-cycle commands broadcast to every cell of the queue.
  typedef struct packed {
    logic add;
    logic pop;
  } clook_ctrl_t;

endpackage

`default_nettype wire

### rtl/clook_cell.sv
// One queue cell of the C-LOOK scheduler: holds one request and shifts with its neighbors.
// Depends on clook_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clook_cell #(
  parameter int TAG_WIDTH = 8
) (
  input  wire                           clk,
  input  clook_pkg::clook_ctrl_t        ctrl,
  input  wire                           occupied,
  input  wire [clook_pkg::SECTOR_W-1:0] head,
  input  wire [clook_pkg::SECTOR_W-1:0] new_sector,
  input  wire                           new_is_write,
  input  wire [TAG_WIDTH-1:0]           new_tag,
  input  wire                           prev_after,
  input  wire [clook_pkg::SECTOR_W-1:0] prev_sector,
  input  wire                           prev_is_write,
  input  wire [TAG_WIDTH-1:0]           prev_tag,
  input  wire [clook_pkg::SECTOR_W-1:0] next_sector,
  input  wire                           next_is_write,
  input  wire [TAG_WIDTH-1:0]           next_tag,
  output logic                          after,
  output logic [clook_pkg::SECTOR_W-1:0] sector,
  output logic                          is_write,
  output logic [TAG_WIDTH-1:0]          tag
);
  import clook_pkg::*;

  logic [SECTOR_W-1:0]  sector_r, sector_nxt;
  logic                 is_write_r, is_write_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic                 below_head;
  logic                 above_new;

  // The new request belongs in front of this cell. Over the queue this flag is
  // a step (clear then set), since the cells are always in C-LOOK order; an
  // empty cell counts as set so that a request with no earlier slot lands at the tail.
  always_comb begin
    below_head = sector_r < head;
    above_new  = sector_r > new_sector;
    if (!occupied) begin
      after = 1'b1;
    end else if (new_sector >= head) begin
      after = below_head || above_new;
    end else begin
      after = below_head && above_new;
    end
  end

  // Add: cells past the slot take their left neighbor, the slot takes the new
  // request. Dispatch: every cell takes its right neighbor.
  always_comb begin
    sector_nxt   = sector_r;
    is_write_nxt = is_write_r;
    tag_nxt      = tag_r;
    if (ctrl.add) begin
      if (prev_after) begin
        sector_nxt   = prev_sector;
        is_write_nxt = prev_is_write;
        tag_nxt      = prev_tag;
      end else if (after) begin
        sector_nxt   = new_sector;
        is_write_nxt = new_is_write;
        tag_nxt      = new_tag;
      end
    end else if (ctrl.pop) begin
      sector_nxt   = next_sector;
      is_write_nxt = next_is_write;
      tag_nxt      = next_tag;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    sector_r   <= sector_nxt;
    is_write_r <= is_write_nxt;
    tag_r      <= tag_nxt;
  end

  assign sector   = sector_r;
  assign is_write = is_write_r;
  assign tag      = tag_r;

endmodule

`default_nettype wire

### rtl/clook_request_scheduler_core.sv
// Top level of the C-LOOK request scheduler: count, head position and a chain of cells.
// Depends on clook_pkg and clook_cell.
`timescale 1ns / 1ps
`default_nettype none

// The scheduler takes one command beat per clock cycle (add or dispatch) whenever
// busy is low; busy is high only in reset and until the first clock edge after
// it. The result appears on out_item with out_valid high for exactly one cycle,
// the cycle right after the command was taken, and the receiver has no way to
// hold it off, so it must capture it then. Each of the QUEUE_DEPTH cells compares
// its own sector with the head and the new sector, so the insertion slot is found
// and the whole queue shifts in the same cycle; that per-cell compare and shift
// sets the single-cycle rate. No clearing pass follows reset.
module clook_request_scheduler_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  clook_pkg::clook_in_t   in_item,
  output logic                   out_valid,
  output clook_pkg::clook_out_t  out_item
);
  import clook_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SECTOR_W-1:0] head_r, head_nxt;
  logic                busy_r;
  logic                out_valid_r, out_valid_nxt;
  clook_out_t          out_item_r, out_item_nxt;
  logic                accept;
  logic                is_full, is_empty;
  clook_ctrl_t         ctrl;

  logic [SECTOR_W-1:0]  cell_sector   [QUEUE_DEPTH];
  logic                 cell_is_write [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag      [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_after;

  logic [TAG_MAX_W-1:0] new_tag_wide;
  logic [TAG_WIDTH-1:0] new_tag;
  logic [TAG_MAX_W-1:0] front_tag_wide;
  logic [31:0]          occ_wide;

  // Command decode.
  assign accept   = start && !busy_r;
  assign is_full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign is_empty = count_r == '0;
  assign ctrl.add = accept && (in_item.operation == OP_ADD) && !is_full;
  assign ctrl.pop = accept && (in_item.operation == OP_DISPATCH) && !is_empty;

  // Only the low TAG_WIDTH bits of the tag are kept.
  assign new_tag_wide   = TAG_MAX_W'(in_item.tag);
  assign new_tag        = new_tag_wide[TAG_WIDTH-1:0];
  assign front_tag_wide = TAG_MAX_W'(cell_tag[0]);

  // Chain of cells; cell 0 is the front of the queue.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

    clook_cell #(
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occupied      (count_r > CNT_W'(i)),
      .head          (head_r),
      .new_sector    (in_item.sector),
      .new_is_write  (in_item.is_write),
      .new_tag       (new_tag),
      .prev_after    ((i == 0) ? 1'b0 : cell_after[PREV]),
      .prev_sector   (cell_sector[PREV]),
      .prev_is_write (cell_is_write[PREV]),
      .prev_tag      (cell_tag[PREV]),
      .next_sector   (cell_sector[NEXT]),
      .next_is_write (cell_is_write[NEXT]),
      .next_tag      (cell_tag[NEXT]),
      .after         (cell_after[i]),
      .sector        (cell_sector[i]),
      .is_write      (cell_is_write[i]),
      .tag           (cell_tag[i])
    );
  end

  // Count and head update.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    if (ctrl.add) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = cell_sector[0];
    end
  end

  assign occ_wide = 32'(count_nxt);

  // Result beat for the accepted command.
  always_comb begin
    out_valid_nxt             = accept;
    out_item_nxt.status       = ST_ADDED;
    out_item_nxt.out_sector   = '0;
    out_item_nxt.out_is_write = 1'b0;
    out_item_nxt.out_tag      = '0;
    out_item_nxt.occupancy    = occ_wide[OCC_W-1:0];
    unique case (in_item.operation)
      OP_ADD: begin
        out_item_nxt.status = is_full ? ST_FULL : ST_ADDED;
      end
      OP_DISPATCH: begin
        if (is_empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.status       = ST_DISPATCHED;
          out_item_nxt.out_sector   = cell_sector[0];
          out_item_nxt.out_is_write = cell_is_write[0];
          out_item_nxt.out_tag      = front_tag_wide[TAG_IN_W-1:0];
        end
      end
      default: begin
        out_item_nxt.status = ST_ADDED;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### rtl/clook_checker.sv
// Port-level checker for the C-LOOK scheduler, bound to the top level.
// Depends on clook_pkg and clook_request_scheduler_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "clook_request_scheduler_core_defines.svh"

module clook_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   start,
  input wire                   busy,
  input wire                   out_valid,
  input clook_pkg::clook_out_t out_item
);
  import clook_pkg::*;

  localparam logic [31:0] DEPTH_W = 32'(QUEUE_DEPTH);

  logic took_cmd;
  logic other_beat;
  logic payload_clear;
  logic empty_beat;
  logic full_beat;

  // Decoded views of the result beat.
  assign took_cmd      = start && !busy;
  assign other_beat    = out_valid && (out_item.status != ST_DISPATCHED);
  assign payload_clear = (out_item.out_sector == '0) && !out_item.out_is_write &&
                         (out_item.out_tag == '0);
  assign empty_beat    = out_valid && (out_item.status == ST_EMPTY);
  assign full_beat     = out_valid && (out_item.status == ST_FULL);

  // Exactly one result beat follows each accepted command, in the cycle after it.
  `CLOOK_ASSERT(a_one_result, out_valid == $past(took_cmd), "result beat without a command")

  // Only a dispatch carries request payload.
  `CLOOK_ASSERT(a_idle_payload, other_beat |-> payload_clear, "payload on non-dispatch result")

  // An empty report leaves nothing queued; a drop reports a full queue.
  `CLOOK_ASSERT(a_empty_occ, empty_beat |-> (out_item.occupancy == '0), "empty status, queue busy")
  `CLOOK_ASSERT(a_full_occ, full_beat |-> (out_item.occupancy == DEPTH_W[OCC_W-1:0]), "full too low")

  // No result beat while reset holds.
  `CLOOK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result beat after reset")

endmodule

bind clook_request_scheduler_core clook_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_clook_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
